// ===== rtl/bsmd_pkg.sv =====
// ----------------------------------------------------------------------------
// bsmd_pkg: shared types and constants of the bank-switched memory decoder
// Bus-event mode codes, answering-unit codes, memory map windows, bank state
// and result record, and the keyboard row wiring.
// ----------------------------------------------------------------------------
package bsmd_pkg;

	// bus event kinds
	localparam logic [1:0] MODE_MEM_RD  = 2'd0;
	localparam logic [1:0] MODE_MEM_WR  = 2'd1;
	localparam logic [1:0] MODE_PORT_WR = 2'd2;
	localparam logic [1:0] MODE_INT_ACK = 2'd3;

	// answering unit
	localparam logic [2:0] TGT_NONE = 3'd0;
	localparam logic [2:0] TGT_RAM  = 3'd1;
	localparam logic [2:0] TGT_ROM  = 3'd2;
	localparam logic [2:0] TGT_FDC  = 3'd3;
	localparam logic [2:0] TGT_KBD  = 3'd4;
	localparam logic [2:0] TGT_IEEE = 3'd5;
	localparam logic [2:0] TGT_VPIA = 3'd6;

	// 4K windows, address bits 15..12
	localparam logic [3:0] REGION_ROM   = 4'h0;
	localparam logic [3:0] REGION_IO    = 4'h2;
	localparam logic [3:0] REGION_VIDEO = 4'hF;

	// I/O select, address bits 11..8
	localparam logic [3:0] IO_SEL_FDC  = 4'h1;
	localparam logic [3:0] IO_SEL_KBD  = 4'h2;
	localparam logic [3:0] IO_SEL_IEEE = 4'h9;
	localparam logic [3:0] IO_SEL_VPIA = 4'hC;

	// bank port numbers
	localparam logic [1:0] PORT_RAM_MODE = 2'd1;
	localparam logic [1:0] PORT_ATTR     = 2'd2;

	localparam logic [7:0] ACK_VECTOR = 8'hF8;
	localparam logic [7:0] ATTR_OR    = 8'h7F;

	// keyboard: address bit n drives row ROW_OF_BIT[n]
	localparam logic [2:0] ROW_OF_BIT [8] = '{3'd0, 3'd1, 3'd3, 3'd4, 3'd5, 3'd2, 3'd6, 3'd7};

	typedef struct packed {
		logic       rom_io_mapped;
		logic       attr_plane;
		logic [1:0] last_bank_port;
		logic       in_interrupt;
	} bank_state_t;

	typedef struct packed {
		logic [2:0]  target;
		logic        mem_write;
		logic [16:0] mem_addr;
		logic [7:0]  write_data;
		logic        dev_write;
		logic [1:0]  dev_reg;
		logic [7:0]  row_select;
		logic [7:0]  int_vector;
	} dec_result_t;

	function automatic logic [2:0] io_target(input logic [3:0] sel);
		logic [2:0] t;
		case (sel)
			IO_SEL_FDC:  t = TGT_FDC;
			IO_SEL_KBD:  t = TGT_KBD;
			IO_SEL_IEEE: t = TGT_IEEE;
			IO_SEL_VPIA: t = TGT_VPIA;
			default:     t = TGT_NONE;
		endcase
		return t;
	endfunction

	function automatic logic [7:0] wired_rows(input logic [7:0] a);
		logic [7:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (a[i]) m[ROW_OF_BIT[i]] = 1'b1;
		end
		return m;
	endfunction

endpackage

// ===== rtl/bsmd_decode.sv =====
// ----------------------------------------------------------------------------
// bsmd_decode: single bus event decode
// Map one bus event against the current bank state; give the result record
// and the bank state that follows the event.
// ----------------------------------------------------------------------------
module bsmd_decode import bsmd_pkg::*; (
	input  logic [1:0]  mode,
	input  logic [15:0] address,
	input  logic [7:0]  data,
	input  bank_state_t st,
	output bank_state_t st_next,
	output dec_result_t res
);

	logic [3:0] region;
	logic       low;
	logic       is_wr;
	logic       through;
	logic [2:0] io_t;

	assign region  = address[15:12];
	assign low     = (address[15:14] == 2'b00);
	assign is_wr   = (mode == MODE_MEM_WR);
	// interrupt handler running from RAM mode: writes also land in RAM
	assign through = is_wr && st.in_interrupt && (st.last_bank_port == PORT_RAM_MODE);
	assign io_t    = io_target(address[11:8]);

	always_comb begin
		res     = '0;
		st_next = st;
		case (mode)
			MODE_PORT_WR: begin
				st_next.rom_io_mapped  = (address[1:0] != PORT_RAM_MODE);
				st_next.attr_plane     = (address[1:0] == PORT_ATTR);
				st_next.last_bank_port = address[1:0];
				st_next.in_interrupt   = 1'b0;
			end
			MODE_INT_ACK: begin
				st_next.rom_io_mapped = 1'b1;
				st_next.attr_plane    = 1'b0;
				st_next.in_interrupt  = 1'b1;
				res.int_vector        = ACK_VECTOR;
			end
			default: begin
				if (region == REGION_VIDEO) begin
					res.target   = TGT_RAM;
					res.mem_addr = st.attr_plane ? {1'b1, 4'h0, address[11:0]}
					                             : {1'b0, address};
					if (is_wr) begin
						res.mem_write  = 1'b1;
						res.write_data = st.attr_plane ? (data | ATTR_OR) : data;
					end
				end else if (!low || !st.rom_io_mapped) begin
					res.target   = TGT_RAM;
					res.mem_addr = {1'b0, address};
					if (is_wr) begin
						res.mem_write  = 1'b1;
						res.write_data = data;
					end
				end else begin
					if (is_wr) res.write_data = data;
					if (region == REGION_IO) begin
						if (!is_wr) begin
							res.target = io_t;
							if (io_t == TGT_KBD) res.row_select = wired_rows(address[7:0]);
							else if (io_t != TGT_NONE) res.dev_reg = address[1:0];
						end else begin
							// keyboard has no write side
							if (io_t != TGT_NONE && io_t != TGT_KBD) begin
								res.target    = io_t;
								res.dev_write = 1'b1;
								res.dev_reg   = address[1:0];
							end else begin
								res.target = through ? TGT_RAM : TGT_NONE;
							end
							if (through) begin
								res.mem_write = 1'b1;
								res.mem_addr  = {1'b0, address};
							end
						end
					end else if (through) begin
						res.target    = TGT_RAM;
						res.mem_write = 1'b1;
						res.mem_addr  = {1'b0, address};
					end else if (region == REGION_ROM) begin
						res.target   = TGT_ROM;
						res.mem_addr = {1'b0, address};
					end
				end
			end
		endcase
	end

endmodule

// ===== rtl/bank_switched_memory_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// bank_switched_memory_decoder_unit: processor bus decoder with bank switching
// Input register, one-pass decode with bank state update, result register.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side s_*: one bus event per beat. s_tuser carries the event mode,
//   s_tdata the address and write data. Master side m_*: one result beat per
//   event. m_tuser carries the answering unit, m_tdata the remaining fields.
//   Path: a taken beat passes two register stages, the input register and
//   then the result register, before it appears on m_*.
//   Throughput: one beat per cycle while the result register is empty or
//   being taken; both stages then advance together.
//   The bank state (ROM/IO mapping, attribute plane, last bank port,
//   interrupt flag) is updated as an event moves from the input register
//   into the result register, so events see it in strict arrival order.
//   Reset: arst_n low empties both stages and returns to ROM/IO-mapped mode
//   with the attribute plane off, bank port 0 and no interrupt pending.
//   Stall: with m_tready low the result holds; an empty input register still
//   takes one more beat, and s_tready stays low while the input register is
//   full, until the result is taken.
// ----------------------------------------------------------------------------
module bank_switched_memory_decoder_unit import bsmd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [15:0] address, [23:16] data
	input  logic [1:0]  s_tuser,  // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // [0] mem_write, [17:1] mem_addr, [25:18] write_data,
	                              // [26] dev_write, [28:27] dev_reg, [36:29] row_select,
	                              // [44:37] int_vector, [47:45] zero
	output logic [2:0]  m_tuser   // [2:0] target
);

	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;
	logic        valid_s2;
	dec_result_t res_s2;
	bank_state_t st_q;
	bank_state_t st_next;
	dec_result_t res;
	logic        adv_s2;
	logic        adv_s1;

	// result register frees when empty or taken this cycle
	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= s_tuser;
			addr_s1 <= s_tdata[15:0];
			data_s1 <= s_tdata[23:16];
		end
	end

	bsmd_decode u_decode (
		.mode    (mode_s1),
		.address (addr_s1),
		.data    (data_s1),
		.st      (st_q),
		.st_next (st_next),
		.res     (res)
	);

	// bank state: commit only when the event leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{rom_io_mapped: 1'b1, attr_plane: 1'b0, last_bank_port: 2'd0,
			          in_interrupt: 1'b0};
		end else if (adv_s1) begin
			st_q <= st_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.target;
	assign m_tdata  = {3'b000, res_s2.int_vector, res_s2.row_select, res_s2.dev_reg,
	                   res_s2.dev_write, res_s2.write_data, res_s2.mem_addr,
	                   res_s2.mem_write};

	// acknowledge always lands in mapped mode with the interrupt flag set
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && mode_s1 == MODE_INT_ACK |=>
			st_q.in_interrupt && st_q.rom_io_mapped && !st_q.attr_plane)
		else $error("acknowledge did not force mapped mode");

	// a port write records its port and ends the interrupt
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && mode_s1 == MODE_PORT_WR |=>
			!st_q.in_interrupt && st_q.last_bank_port == $past(addr_s1[1:0]))
		else $error("port write did not update bank state");

	// an event leaving the input register is always held as a result
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2)
		else $error("decoded event lost");

	// RAM write enable only on RAM or a writable device in write-through
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.mem_write |->
			res_s2.target == TGT_RAM || res_s2.target == TGT_FDC ||
			res_s2.target == TGT_IEEE || res_s2.target == TGT_VPIA)
		else $error("RAM write on wrong target");

	// device strobes never come with an interrupt vector
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.int_vector != 8'd0 |->
			!res_s2.dev_write && !res_s2.mem_write && res_s2.target == TGT_NONE)
		else $error("acknowledge result not clean");

endmodule
